// ===== rtl/tpls_pkg.sv =====
// Package for the two-peer link supervisor: link, command and message codes,
// register indexes and reset values, and the structs shared by the modules.
// No dependencies.
package tpls_pkg;

   typedef enum logic [1:0] {
      LINK_SEARCHING    = 2'd0,
      LINK_CONNECTED    = 2'd1,
      LINK_DISCONNECTED = 2'd2
   } link_type;

   typedef enum logic [1:0] {
      CMD_POLL   = 2'd0,
      CMD_REPORT = 2'd1,
      CMD_WAKE   = 2'd2,
      CMD_QUEUE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STATUS      = 2'd0,
      KIND_MODE_UPDATE = 2'd1,
      KIND_FRAME       = 2'd2
   } kind_type;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_MODE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEARCH_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_INTERVAL   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEARTBEAT       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_INTERVAL = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_INTERVAL   = 3'd5;

   localparam logic [1:0]  MODE_IDLE_A = 2'd1;
   localparam logic [1:0]  MODE_IDLE_B = 2'd3;

   localparam logic [15:0] RST_SEARCH_TIMEOUT  = 16'd10000;
   localparam logic [15:0] RST_FAST_INTERVAL   = 16'd250;
   localparam logic [15:0] RST_HEARTBEAT       = 16'd3000;
   localparam logic [15:0] RST_ACTIVE_INTERVAL = 16'd10;
   localparam logic [15:0] RST_IDLE_INTERVAL   = 16'd500;

   typedef struct packed {
      logic [1:0]  input_mode;
      logic [15:0] search_timeout;
      logic [15:0] fast_interval;
      logic [15:0] heartbeat_interval;
      logic [15:0] active_interval;
      logic [15:0] idle_interval;
   } cfg_type;

   typedef struct packed {
      link_type rx_link;
      link_type gl_link;
      logic     rx_fail_armed;
      logic     rx_search_off;
      logic     gl_fail_armed;
      logic     gl_search_off;
      logic     update_pending;
      logic     gl_sent_once;
   } ctl_type;

   typedef struct packed {
      kind_type   kind;
      logic       wake;
      logic [1:0] mode;
      link_type   rx_status;
      link_type   gl_status;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/tpls_step.sv =====
// Next-state and result logic for one transaction of the link supervisor.
// Purely combinational; depends on tpls_pkg.
module tpls_step #(
   parameter int TIME_BITS = 32
) (
   input  tpls_pkg::cfg_type         cfg,
   input  tpls_pkg::ctl_type         ctl,
   input  logic [TIME_BITS-1:0]      rx_fail_start,
   input  logic [TIME_BITS-1:0]      gl_fail_start,
   input  logic [TIME_BITS-1:0]      gl_last_send,
   input  logic [TIME_BITS-1:0]      rx_last_send,
   input  logic [1:0]                command,
   input  logic [TIME_BITS-1:0]      now,
   input  logic                      peer,
   input  logic                      success,
   output tpls_pkg::ctl_type         ctl_in,
   output logic [TIME_BITS-1:0]      rx_fail_start_in,
   output logic [TIME_BITS-1:0]      gl_fail_start_in,
   output logic [TIME_BITS-1:0]      gl_last_send_in,
   output logic [TIME_BITS-1:0]      rx_last_send_in,
   output tpls_pkg::rsp_type         res0,
   output tpls_pkg::rsp_type         res1,
   output logic                      two_results
);
   import tpls_pkg::*;

   logic [TIME_BITS-1:0] rx_fail_el;
   logic [TIME_BITS-1:0] gl_fail_el;
   logic [TIME_BITS-1:0] gl_send_el;
   logic [TIME_BITS-1:0] rx_send_el;
   logic [TIME_BITS-1:0] gap;
   logic [TIME_BITS-1:0] fgap;
   logic                 searching;
   logic                 sched;
   logic                 wake;
   logic                 gl_due;
   logic                 frame_due;
   logic                 frame_emit;
   rsp_type              upd_rsp;
   rsp_type              frm_rsp;
   rsp_type              sts_rsp;

   assign rx_fail_el = now - rx_fail_start;
   assign gl_fail_el = now - gl_fail_start;
   assign gl_send_el = now - gl_last_send;
   assign rx_send_el = now - rx_last_send;

   always_comb begin
      ctl_in           = ctl;
      rx_fail_start_in = rx_fail_start;
      gl_fail_start_in = gl_fail_start;
      gl_last_send_in  = gl_last_send;
      rx_last_send_in  = rx_last_send;
      searching        = 1'b0;
      sched            = 1'b0;
      wake             = 1'b0;
      gap              = '0;
      fgap             = '0;
      gl_due           = 1'b0;
      frame_due        = 1'b0;
      frame_emit       = 1'b0;

      unique case (cmd_type'(command)) inside
         CMD_REPORT: begin
            if (!peer) begin
               if (success) begin
                  ctl_in.rx_search_off = 1'b0;
                  ctl_in.rx_fail_armed = 1'b0;
                  rx_fail_start_in     = '0;
                  ctl_in.rx_link       = LINK_CONNECTED;
               end else if (!ctl.rx_fail_armed) begin
                  ctl_in.rx_fail_armed = 1'b1;
                  rx_fail_start_in     = now;
                  ctl_in.rx_link       = LINK_SEARCHING;
               end
            end else begin
               if (success) begin
                  ctl_in.gl_search_off  = 1'b0;
                  ctl_in.gl_fail_armed  = 1'b0;
                  gl_fail_start_in      = '0;
                  ctl_in.gl_link        = LINK_CONNECTED;
                  ctl_in.update_pending = 1'b0;
               end else if (!ctl.gl_fail_armed) begin
                  ctl_in.gl_fail_armed = 1'b1;
                  gl_fail_start_in     = now;
                  ctl_in.gl_link       = LINK_SEARCHING;
               end
            end
         end
         CMD_WAKE, CMD_QUEUE: begin
            if (cmd_type'(command) == CMD_WAKE) begin
               ctl_in.rx_search_off = 1'b0;
               ctl_in.rx_fail_armed = 1'b0;
               rx_fail_start_in     = '0;
               ctl_in.rx_link       = LINK_SEARCHING;
            end
            ctl_in.gl_search_off  = 1'b0;
            ctl_in.gl_fail_armed  = 1'b0;
            gl_fail_start_in      = '0;
            ctl_in.gl_link        = LINK_SEARCHING;
            ctl_in.update_pending = 1'b1;
            ctl_in.gl_sent_once   = 1'b0;
         end
         default: begin
            if (!ctl.rx_search_off && ctl.rx_fail_armed &&
                rx_fail_el > TIME_BITS'(cfg.search_timeout)) begin
               ctl_in.rx_search_off = 1'b1;
               ctl_in.rx_link       = LINK_DISCONNECTED;
            end
            if (!ctl.gl_search_off && ctl.gl_fail_armed &&
                gl_fail_el > TIME_BITS'(cfg.search_timeout)) begin
               ctl_in.gl_search_off = 1'b1;
               ctl_in.gl_link       = LINK_DISCONNECTED;
            end
            if (!(ctl_in.rx_search_off && ctl_in.gl_search_off)) begin
               searching = (ctl_in.gl_link == LINK_SEARCHING) && !ctl_in.gl_search_off;
               if (ctl.update_pending || searching) begin
                  sched = 1'b1;
                  gap   = TIME_BITS'(cfg.fast_interval);
                  wake  = 1'b1;
               end else if (ctl_in.gl_link == LINK_CONNECTED) begin
                  sched = 1'b1;
                  gap   = TIME_BITS'(cfg.heartbeat_interval);
               end
               gl_due = sched && (!ctl.gl_sent_once || gl_send_el >= gap);
               if (gl_due) begin
                  gl_last_send_in     = now;
                  ctl_in.gl_sent_once = 1'b1;
               end
               fgap = (cfg.input_mode == MODE_IDLE_A || cfg.input_mode == MODE_IDLE_B) ?
                      TIME_BITS'(cfg.idle_interval) : TIME_BITS'(cfg.active_interval);
               frame_due = rx_send_el >= fgap;
               if (frame_due) begin
                  rx_last_send_in = now;
               end
               frame_emit = frame_due && !ctl_in.rx_search_off;
            end
         end
      endcase
   end

   always_comb begin
      sts_rsp           = '0;
      sts_rsp.kind      = KIND_STATUS;
      sts_rsp.rx_status = ctl_in.rx_link;
      sts_rsp.gl_status = ctl_in.gl_link;
      sts_rsp.last      = 1'b1;

      upd_rsp      = sts_rsp;
      upd_rsp.kind = KIND_MODE_UPDATE;
      upd_rsp.wake = wake;
      upd_rsp.mode = cfg.input_mode;
      upd_rsp.last = !frame_emit;

      frm_rsp      = sts_rsp;
      frm_rsp.kind = KIND_FRAME;
      frm_rsp.mode = cfg.input_mode;

      two_results = gl_due && frame_emit;
      res1        = frm_rsp;
      if (gl_due) begin
         res0 = upd_rsp;
      end else if (frame_emit) begin
         res0 = frm_rsp;
      end else begin
         res0 = sts_rsp;
      end
   end

endmodule

// ===== rtl/tpls_rsp_queue.sv =====
// Four-entry result queue: takes one or two results a cycle, hands out one.
// Depends on tpls_pkg.
module tpls_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              push_two,
   input  tpls_pkg::rsp_type d0,
   input  tpls_pkg::rsp_type d1,
   input  logic              pop,
   output logic              room,
   output logic              head_valid,
   output tpls_pkg::rsp_type head
);
   import tpls_pkg::*;

   rsp_type    slot_ff [4];
   logic [1:0] wr_ff;
   logic [1:0] wr_in;
   logic [1:0] rd_ff;
   logic [1:0] rd_in;
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic [2:0] push_cnt;
   logic       pop_ok;

   assign pop_ok     = pop && (count_ff != 3'd0);
   assign push_cnt   = push ? (push_two ? 3'd2 : 3'd1) : 3'd0;
   assign wr_in      = wr_ff + push_cnt[1:0];
   assign rd_in      = rd_ff + {1'b0, pop_ok};
   assign count_in   = count_ff + push_cnt - {2'b00, pop_ok};
   assign room       = count_ff <= 3'd2;
   assign head_valid = count_ff != 3'd0;
   assign head       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= d0;
      end
      if (push && push_two) begin
         slot_ff[wr_ff + 2'd1] <= d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/two_peer_link_supervisor_top.sv =====
// Two-peer link supervisor: link state, fail timers and message scheduling.
// The results of a transaction are registered in the result queue and offered from its head.
// Throughput: one transaction per cycle while req_ready is high; results leave at one per
// cycle while rsp_ready is high, so a transaction with two results holds the output for both.
// The four-entry result queue drops req_ready while fewer than two entries are free.
// Reset (synchronous): links searching, timers cleared, queue empty, registers at defaults.
module two_peer_link_supervisor_top #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_now_ms,
   input  logic        req_peer,
   input  logic        req_success,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_message_kind,
   output logic        rsp_wake_flag,
   output logic [1:0]  rsp_mode_sent,
   output logic [1:0]  rsp_receiver_status,
   output logic [1:0]  rsp_glove_status,
   output logic        rsp_last_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tpls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   import tpls_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   ctl_type              ctl_ff;
   ctl_type              ctl_in;
   logic [TIME_BITS-1:0] rx_fail_start_ff;
   logic [TIME_BITS-1:0] rx_fail_start_in;
   logic [TIME_BITS-1:0] gl_fail_start_ff;
   logic [TIME_BITS-1:0] gl_fail_start_in;
   logic [TIME_BITS-1:0] gl_last_send_ff;
   logic [TIME_BITS-1:0] gl_last_send_in;
   logic [TIME_BITS-1:0] rx_last_send_ff;
   logic [TIME_BITS-1:0] rx_last_send_in;
   logic [TIME_BITS-1:0] now;
   logic                 accept;
   logic                 two_results;
   rsp_type              res0;
   rsp_type              res1;
   rsp_type              head;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign now       = TIME_BITS'(req_now_ms);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INPUT_MODE:      cfg_in.input_mode         = csr_wdata[1:0];
            CSR_SEARCH_TIMEOUT:  cfg_in.search_timeout     = csr_wdata;
            CSR_FAST_INTERVAL:   cfg_in.fast_interval      = csr_wdata;
            CSR_HEARTBEAT:       cfg_in.heartbeat_interval = csr_wdata;
            CSR_ACTIVE_INTERVAL: cfg_in.active_interval    = csr_wdata;
            CSR_IDLE_INTERVAL:   cfg_in.idle_interval      = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   tpls_step #(
      .TIME_BITS(TIME_BITS)
   ) u_step (
      .cfg              (cfg_ff),
      .ctl              (ctl_ff),
      .rx_fail_start    (rx_fail_start_ff),
      .gl_fail_start    (gl_fail_start_ff),
      .gl_last_send     (gl_last_send_ff),
      .rx_last_send     (rx_last_send_ff),
      .command          (req_command),
      .now              (now),
      .peer             (req_peer),
      .success          (req_success),
      .ctl_in           (ctl_in),
      .rx_fail_start_in (rx_fail_start_in),
      .gl_fail_start_in (gl_fail_start_in),
      .gl_last_send_in  (gl_last_send_in),
      .rx_last_send_in  (rx_last_send_in),
      .res0             (res0),
      .res1             (res1),
      .two_results      (two_results)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_mode         <= '0;
         cfg_ff.search_timeout     <= RST_SEARCH_TIMEOUT;
         cfg_ff.fast_interval      <= RST_FAST_INTERVAL;
         cfg_ff.heartbeat_interval <= RST_HEARTBEAT;
         cfg_ff.active_interval    <= RST_ACTIVE_INTERVAL;
         cfg_ff.idle_interval      <= RST_IDLE_INTERVAL;
         ctl_ff.rx_link            <= LINK_SEARCHING;
         ctl_ff.gl_link            <= LINK_SEARCHING;
         ctl_ff.rx_fail_armed      <= 1'b0;
         ctl_ff.rx_search_off      <= 1'b0;
         ctl_ff.gl_fail_armed      <= 1'b0;
         ctl_ff.gl_search_off      <= 1'b0;
         ctl_ff.update_pending     <= 1'b0;
         ctl_ff.gl_sent_once       <= 1'b0;
         rx_fail_start_ff          <= '0;
         gl_fail_start_ff          <= '0;
         gl_last_send_ff           <= '0;
         rx_last_send_ff           <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            ctl_ff           <= ctl_in;
            rx_fail_start_ff <= rx_fail_start_in;
            gl_fail_start_ff <= gl_fail_start_in;
            gl_last_send_ff  <= gl_last_send_in;
            rx_last_send_ff  <= rx_last_send_in;
         end
      end
   end

   tpls_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_two   (two_results),
      .d0         (res0),
      .d1         (res1),
      .pop        (rsp_ready),
      .room       (req_ready),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_message_kind    = head.kind;
   assign rsp_wake_flag       = head.wake;
   assign rsp_mode_sent       = head.mode;
   assign rsp_receiver_status = head.rx_status;
   assign rsp_glove_status    = head.gl_status;
   assign rsp_last_item       = head.last;

endmodule
